// ===== design/iphs_pkg.sv =====
`default_nettype none
package iphs_pkg;
    localparam int CAPACITY = 256;
    localparam int ID_BITS = 16;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int LINK_W = SLOT_W + 1;
    localparam logic [LINK_W-1:0] EMPTY_MARK = LINK_W'(CAPACITY);

    localparam logic [1:0] FUNC_FIND = 2'd0;
    localparam logic [1:0] FUNC_ADD = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    localparam logic [2:0] ST_ABSENT = 3'd0;
    localparam logic [2:0] ST_PRESENT = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_REMOVED = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,       // latch item, compute bucket, read head
        OP_WALK_RD,    // read pair/link of cur
        OP_WALK_STEP,  // advance cur
        OP_ADD,        // write new pair, link, head
        OP_UNLINK_INIT,// start unlink walk for target in bucket
        OP_UNLINK_FIX, // patch predecessor or head
        OP_LAST_RD,    // read pair at last slot
        OP_LAST_HASH,  // rehash last pair, set target
        OP_MOVE,       // copy last pair into freed slot, relink
        OP_DEC         // count minus one
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   unlink_mode;
    } dp_cmd_t;

    typedef struct packed {
        logic head_ready;
        logic walk_end;
        logic walk_hit;
        logic full;
        logic last_is_found;
    } dp_stat_t;

    function automatic logic [SLOT_W-1:0] bucket_of(input logic [ID_BITS-1:0] lo,
                                                    input logic [ID_BITS-1:0] hi);
        logic [ID_BITS-1:0] x;
        logic [ID_BITS-1:0] r;
        x = lo ^ {hi[ID_BITS/2-1:0], hi[ID_BITS-1:ID_BITS/2]} ^ (hi >> 3);
        r = x ^ (x >> SLOT_W);
        return r[SLOT_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== design/iphs_datapath.sv =====
`default_nettype none
module iphs_datapath
    import iphs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dp_cmd_t            cmd,
    input  wire logic [1:0]         s_func,
    input  wire logic [ID_BITS-1:0] s_id_a,
    input  wire logic [ID_BITS-1:0] s_id_b,
    output dp_stat_t                stat,
    output logic [1:0]              func_q,
    output logic [SLOT_W-1:0]       found_slot,
    output logic [LINK_W-1:0]       count_q
);
    logic [LINK_W-1:0] head_mem [CAPACITY];
    logic [LINK_W-1:0] link_mem [CAPACITY];
    logic [2*ID_BITS-1:0] pair_mem [CAPACITY];
    logic [CAPACITY-1:0] head_valid_reg;

    logic [1:0] func_reg;
    logic [ID_BITS-1:0] lo_reg, hi_reg;
    logic [SLOT_W-1:0] bucket_reg;
    logic [LINK_W-1:0] count_reg;
    logic [LINK_W-1:0] cur_reg, prev_reg, target_reg;
    logic [SLOT_W-1:0] found_reg;
    logic [LINK_W-1:0] head_rd_reg, link_rd_reg;
    logic [2*ID_BITS-1:0] pair_rd_reg;
    logic head_pend_reg;
    logic head_ok_reg;

    logic [ID_BITS-1:0] a, b, lo_n, hi_n;
    logic [SLOT_W-1:0] last_slot;
    logic [LINK_W-1:0] head_val;

    assign a = s_id_a;
    assign b = s_id_b;
    assign lo_n = (a < b) ? a : b;
    assign hi_n = (a < b) ? b : a;
    assign last_slot = SLOT_W'(count_reg - LINK_W'(1));
    assign head_val = head_valid_reg[bucket_reg] ? head_rd_reg : EMPTY_MARK;

    always_comb begin
        stat.head_ready = head_ok_reg;
        if (cmd.unlink_mode)
            stat.walk_end = (cur_reg == target_reg) || (cur_reg >= count_reg);
        else
            stat.walk_end = (cur_reg >= count_reg);
        stat.walk_hit = !cmd.unlink_mode && (cur_reg < count_reg)
                        && (pair_rd_reg == {lo_reg, hi_reg});
        stat.full = (count_reg >= LINK_W'(CAPACITY));
        stat.last_is_found = (last_slot == found_reg);
    end

    assign func_q = func_reg;
    assign found_slot = found_reg;
    assign count_q = count_reg;

    // memory ports
    always_ff @(posedge aclk) begin
        head_rd_reg <= head_mem[bucket_reg];
        link_rd_reg <= link_mem[cur_reg[SLOT_W-1:0]];
        pair_rd_reg <= pair_mem[(cmd.op == OP_LAST_RD) ? last_slot : cur_reg[SLOT_W-1:0]];
        case (cmd.op)
            OP_ADD: begin
                pair_mem[count_reg[SLOT_W-1:0]] <= {lo_reg, hi_reg};
                link_mem[count_reg[SLOT_W-1:0]] <= head_val;
                head_mem[bucket_reg] <= count_reg;
            end
            OP_UNLINK_FIX: begin
                if (cur_reg == target_reg) begin
                    if (prev_reg != EMPTY_MARK)
                        link_mem[prev_reg[SLOT_W-1:0]] <= link_rd_reg;
                    else
                        head_mem[bucket_reg] <= link_rd_reg;
                end
            end
            OP_MOVE: begin
                pair_mem[found_reg] <= {lo_reg, hi_reg};
                link_mem[found_reg] <= head_val;
                head_mem[bucket_reg] <= {1'b0, found_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            head_valid_reg <= '0;
            head_pend_reg <= 1'b0;
            head_ok_reg <= 1'b0;
        end else begin
            case (cmd.op)
                OP_LOAD: begin
                    func_reg <= s_func;
                    lo_reg <= lo_n;
                    hi_reg <= hi_n;
                    bucket_reg <= bucket_of(lo_n, hi_n);
                    cur_reg <= EMPTY_MARK;
                end
                OP_WALK_RD: begin
                    if (head_ok_reg) begin
                        cur_reg <= head_val;
                        prev_reg <= EMPTY_MARK;
                    end
                end
                OP_WALK_STEP: begin
                    if (stat.walk_hit)
                        found_reg <= cur_reg[SLOT_W-1:0];
                    prev_reg <= cur_reg;
                    cur_reg <= link_rd_reg;
                end
                OP_ADD: begin
                    head_valid_reg[bucket_reg] <= 1'b1;
                    count_reg <= count_reg + LINK_W'(1);
                end
                OP_UNLINK_INIT: begin
                    cur_reg <= EMPTY_MARK;
                end
                OP_UNLINK_FIX: begin
                    cur_reg <= EMPTY_MARK;
                end
                OP_LAST_HASH: begin
                    lo_reg <= pair_rd_reg[2*ID_BITS-1:ID_BITS];
                    hi_reg <= pair_rd_reg[ID_BITS-1:0];
                    bucket_reg <= bucket_of(pair_rd_reg[2*ID_BITS-1:ID_BITS],
                                            pair_rd_reg[ID_BITS-1:0]);
                    target_reg <= {1'b0, last_slot};
                end
                OP_MOVE: begin
                    head_valid_reg[bucket_reg] <= 1'b1;
                end
                OP_DEC: begin
                    count_reg <= count_reg - LINK_W'(1);
                end
                default: begin
                end
            endcase
            // head read lands in the cycle after the bucket settles
            head_pend_reg <= (cmd.op == OP_LOAD) || (cmd.op == OP_UNLINK_INIT)
                             || (cmd.op == OP_LAST_HASH);
            head_ok_reg <= head_pend_reg;
            if (cmd.op == OP_WALK_RD && cmd.unlink_mode == 1'b0 && head_ok_reg)
                target_reg <= EMPTY_MARK;
            if (cmd.op == OP_UNLINK_INIT)
                target_reg <= {1'b0, found_reg};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LINK_W'(CAPACITY))
        else $error("pair count above capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_ADD |=> count_reg == $past(count_reg) + LINK_W'(1))
        else $error("add did not bump count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_DEC |-> count_reg != '0)
        else $error("remove from empty table");
endmodule
`default_nettype wire

// ===== design/iphs_ctrl.sv =====
`default_nettype none
module iphs_ctrl
    import iphs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire dp_stat_t          stat,
    input  wire logic [1:0]        func_q,
    input  wire logic [SLOT_W-1:0] found_slot,
    input  wire logic [LINK_W-1:0] count_q,
    output dp_cmd_t                cmd,
    output logic [2:0]             m_status,
    output logic [7:0]             m_slot,
    output logic                   m_moved,
    output logic [8:0]             m_pair_count
);
    typedef enum logic [3:0] {
        S_IDLE, S_HEAD, S_RD, S_STEP, S_DECIDE, S_ADD,
        S_UHEAD, S_URD, S_USTEP, S_LRD, S_LHASH, S_MWAIT, S_MOVE, S_DEC, S_OUT
    } state_t;

    state_t state_reg;
    logic hit_reg, last_pass_reg, moved_reg;
    logic [2:0] status_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [LINK_W-1:0] steps_reg;
    logic m_valid_reg;

    logic step_limit;
    assign step_limit = (steps_reg == LINK_W'(CAPACITY));

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_status = status_reg;
    assign m_slot = 8'(slot_reg);
    assign m_moved = moved_reg;
    assign m_pair_count = 9'(count_q);

    always_comb begin
        cmd.op = OP_NONE;
        cmd.unlink_mode = 1'b0;
        case (state_reg)
            S_IDLE:   if (s_valid) cmd.op = OP_LOAD;
            S_HEAD:   cmd.op = OP_WALK_RD;
            S_RD:     cmd.op = OP_NONE;
            S_STEP:   cmd.op = OP_WALK_STEP;
            S_ADD:    cmd.op = OP_ADD;
            S_UHEAD:  begin cmd.op = OP_WALK_RD; cmd.unlink_mode = 1'b1; end
            S_URD:    cmd.unlink_mode = 1'b1;
            S_USTEP:  begin
                cmd.unlink_mode = 1'b1;
                cmd.op = (stat.walk_end || step_limit) ? OP_UNLINK_FIX : OP_WALK_STEP;
            end
            S_LRD:    cmd.op = OP_LAST_RD;
            S_LHASH:  cmd.op = OP_LAST_HASH;
            S_MWAIT:  cmd.op = OP_NONE;
            S_MOVE:   cmd.op = OP_MOVE;
            S_DEC:    cmd.op = OP_DEC;
            S_DECIDE: if (func_q == FUNC_REMOVE && hit_reg) cmd.op = OP_UNLINK_INIT;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
            hit_reg <= 1'b0;
            last_pass_reg <= 1'b0;
            moved_reg <= 1'b0;
            status_reg <= ST_ABSENT;
            slot_reg <= '0;
            steps_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        hit_reg <= 1'b0;
                        last_pass_reg <= 1'b0;
                        moved_reg <= 1'b0;
                        steps_reg <= '0;
                        state_reg <= S_HEAD;
                    end
                end
                S_HEAD: if (stat.head_ready) state_reg <= S_RD;
                S_RD: state_reg <= S_STEP;
                S_STEP: begin
                    // stop on hit, chain end or step bound
                    if (stat.walk_hit) begin
                        hit_reg <= 1'b1;
                        state_reg <= S_DECIDE;
                    end else if (stat.walk_end || step_limit) begin
                        state_reg <= S_DECIDE;
                    end else begin
                        steps_reg <= steps_reg + LINK_W'(1);
                        state_reg <= S_RD;
                    end
                end
                S_DECIDE: begin
                    steps_reg <= '0;
                    if (func_q == FUNC_ADD && !hit_reg && !stat.full) begin
                        status_reg <= ST_INSERTED;
                        slot_reg <= SLOT_W'(count_q);
                        state_reg <= S_ADD;
                    end else if (func_q == FUNC_REMOVE && hit_reg) begin
                        status_reg <= ST_REMOVED;
                        slot_reg <= found_slot;
                        state_reg <= S_UHEAD;
                    end else if (func_q == FUNC_ADD && !hit_reg) begin
                        status_reg <= ST_FULL;
                        slot_reg <= '0;
                        state_reg <= S_OUT;
                    end else if (hit_reg && func_q != FUNC_REMOVE) begin
                        status_reg <= ST_PRESENT;
                        slot_reg <= found_slot;
                        state_reg <= S_OUT;
                    end else begin
                        status_reg <= ST_ABSENT;
                        slot_reg <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_ADD: state_reg <= S_OUT;
                S_UHEAD: if (stat.head_ready) state_reg <= S_URD;
                S_URD: state_reg <= S_USTEP;
                S_USTEP: begin
                    if (stat.walk_end || step_limit) begin
                        steps_reg <= '0;
                        if (!last_pass_reg && !stat.last_is_found) begin
                            last_pass_reg <= 1'b1;
                            moved_reg <= 1'b1;
                            state_reg <= S_LRD;
                        end else if (last_pass_reg) begin
                            state_reg <= S_MWAIT;
                        end else begin
                            state_reg <= S_DEC;
                        end
                    end else begin
                        steps_reg <= steps_reg + LINK_W'(1);
                        state_reg <= S_URD;
                    end
                end
                S_LRD: state_reg <= S_LHASH;
                S_LHASH: state_reg <= S_UHEAD;
                // let the unlink head write land before the head is read again
                S_MWAIT: state_reg <= S_MOVE;
                S_MOVE: state_reg <= S_DEC;
                S_DEC: state_reg <= S_OUT;
                S_OUT: begin
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end else begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == S_OUT)
        else $error("result shown outside output state");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_moved |-> status_reg == ST_REMOVED)
        else $error("moved flag without remove");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_slot) && $stable(m_status))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

// ===== design/id_pair_hash_set.sv =====
`default_nettype none
// Chained hash set of unordered id pairs kept in dense slots, 256 pairs max.
// One item at a time: a find walks the bucket chain from its head, with a
// read state and a step state for each entry visited, and an add then
// writes the new pair. A remove adds an unlink walk of the chain and, when
// the last pair moves into the freed slot, a second unlink walk that first
// takes that pair out of its own chain. The chain memories give one
// registered read per cycle. The result is held until taken, so m_ready
// stalls hold off the next item, which is accepted only after that. No
// clearing pass: bucket heads carry valid bits cleared by reset.
module id_pair_hash_set
    import iphs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_func,
    input  wire logic [ID_BITS-1:0] s_id_a,
    input  wire logic [ID_BITS-1:0] s_id_b,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic [7:0]              m_slot,
    output logic                    m_moved,
    output logic [8:0]              m_pair_count
);
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic [1:0] func_q;
    logic [SLOT_W-1:0] found_slot;
    logic [LINK_W-1:0] count_q;

    iphs_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .s_func(s_func), .s_id_a(s_id_a), .s_id_b(s_id_b),
        .stat(stat), .func_q(func_q), .found_slot(found_slot), .count_q(count_q)
    );

    iphs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .stat(stat), .func_q(func_q), .found_slot(found_slot), .count_q(count_q),
        .cmd(cmd), .m_status(m_status), .m_slot(m_slot), .m_moved(m_moved),
        .m_pair_count(m_pair_count)
    );
endmodule
`default_nettype wire
